>>> rtl/cacc_pkg.sv
// shared constants, types and helpers for the complex accumulator alu
`timescale 1ns / 1ps

package cacc_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int SUM_W      = PROD_W + 2;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    typedef logic signed [DATA_WIDTH-1:0] word_t;

    typedef enum logic [2:0] {
        CMD_LOAD = 3'd0,
        CMD_ADD  = 3'd1,
        CMD_SUB  = 3'd2,
        CMD_MUL  = 3'd3,
        CMD_DIV  = 3'd4,
        CMD_MAG  = 3'd5,
        CMD_BAD6 = 3'd6,
        CMD_BAD7 = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_DIV0   = 2'd1,
        ST_ILLEGAL = 2'd2,
        ST_RSVD   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        DST_RE  = 2'd0,
        DST_IM  = 2'd1,
        DST_DEN = 2'd2,
        DST_NONE = 2'd3
    } dst_t;

    // signed word from sign and magnitude, saturated
    function automatic word_t sm_to_word(input logic neg, input logic [SUM_W-1:0] mag);
        logic [SUM_W-1:0] cap;
        word_t            w;
        cap = {{(SUM_W-DATA_WIDTH){1'b0}}, 1'b1, {(DATA_WIDTH-1){1'b0}}};
        if (neg)
        begin
            if (mag >= cap)
                w = {1'b1, {(DATA_WIDTH-1){1'b0}}};
            else
                w = word_t'(-mag[DATA_WIDTH-1:0]);
        end
        else
        begin
            if (mag >= cap)
                w = {1'b0, {(DATA_WIDTH-1){1'b1}}};
            else
                w = word_t'(mag[DATA_WIDTH-1:0]);
        end
        return w;
    endfunction

    // saturating add of two words
    function automatic word_t sat_add(input word_t a, input word_t b);
        logic signed [DATA_WIDTH:0] s;
        word_t                      w;
        s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1])
            w = s[DATA_WIDTH] ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : {1'b0, {(DATA_WIDTH-1){1'b1}}};
        else
            w = s[DATA_WIDTH-1:0];
        return w;
    endfunction

endpackage

>>> rtl/complex_accumulator_alu.sv
// complex accumulator alu: q16.16 complex accumulator with a shared multiplier and divider
`timescale 1ns / 1ps
// load, add, subtract, illegal and divide by zero go straight from the idle state to the done state
// multiply runs 4 products through the one shared 32x32 multiplier
// divide runs 6 products, then 32 restoring quotient steps for each part
// magnitude runs 2 squares, then 32 square root steps
// one request at a time; a new request is taken while the last result still waits
// rst_n clears the accumulator to zero and empties the sequencer and the output register
module complex_accumulator_alu
    import cacc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            cmd,
    input  logic signed [31:0]    operand_real,
    input  logic signed [31:0]    operand_imag,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [31:0]    result_real,
    output logic signed [31:0]    result_imag,
    output logic [31:0]           magnitude_value,
    output logic [1:0]            status
);

    // sequencer states
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MUL    = 7'b0000010,
        S_DIVSET = 7'b0000100,
        S_DIV    = 7'b0001000,
        S_DIVEND = 7'b0010000,
        S_SQRT   = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // request and accumulator
    cmd_t  cmd_reg;
    word_t opr_reg, opi_reg;
    word_t acc_re_reg, acc_im_reg;
    logic  dz_reg;

    // product sequencing: one product per cycle, summed in the following cycle
    logic [2:0]              k_reg;
    logic [2:0]              nprod;
    logic signed [PROD_W-1:0] prod_reg;
    logic                    pv_reg;
    dst_t                    pdst_reg;
    logic                    psub_reg;
    word_t                   mul_a, mul_b;
    dst_t                    mdst;
    logic                    msub;
    logic signed [SUM_W-1:0] sum_re_reg, sum_im_reg;
    logic [PROD_W-1:0]       den_reg;

    // divider
    logic                    dsel_reg;
    logic                    dneg_reg;
    logic                    dovf_reg;
    logic [PROD_W-1:0]       rem_reg;
    logic [DATA_WIDTH-1:0]   nlow_reg;
    logic [DATA_WIDTH-1:0]   quo_reg;
    logic [CNT_W-1:0]        cnt_reg;
    word_t                   qre_reg, qim_reg;
    logic signed [SUM_W-1:0] dsum;
    logic [SUM_W-1:0]        dnum;
    logic [PROD_W-1:0]       rem_sh;
    logic                    q_bit;
    word_t                   qword;

    // square root
    logic [PROD_W-1:0]       sx_reg, sres_reg, sbit_reg;
    logic [PROD_W-1:0]       strial;

    // final values
    logic signed [SUM_W-1:0] mul_sum;
    logic [SUM_W-1:0]        mul_mag;
    word_t                   fin_re, fin_im;
    logic [31:0]             fin_mag;
    status_t                 fin_st;
    logic                    finish;

    // output register
    logic                    out_valid_reg;
    word_t                   res_re_reg, res_im_reg;
    logic [31:0]             mag_reg;
    status_t                 st_reg;

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = out_valid_reg;
    assign result_real     = res_re_reg;
    assign result_imag     = res_im_reg;
    assign magnitude_value = mag_reg;
    assign status          = st_reg;

    // multiplier schedule per command
    always_comb
    begin
        mul_a = acc_re_reg;
        mul_b = opr_reg;
        mdst  = DST_NONE;
        msub  = 1'b0;
        unique case (cmd_reg)
            CMD_MUL: nprod = 3'd4;
            CMD_DIV: nprod = 3'd6;
            CMD_MAG: nprod = 3'd2;
            default: nprod = 3'd0;
        endcase
        if (cmd_reg == CMD_MUL)
        begin
            unique case (k_reg)
                3'd0:    begin mul_a = acc_re_reg; mul_b = opr_reg; mdst = DST_RE; end
                3'd1:    begin mul_a = acc_im_reg; mul_b = opi_reg; mdst = DST_RE; msub = 1'b1; end
                3'd2:    begin mul_a = acc_re_reg; mul_b = opi_reg; mdst = DST_IM; end
                3'd3:    begin mul_a = acc_im_reg; mul_b = opr_reg; mdst = DST_IM; end
                default: mdst = DST_NONE;
            endcase
        end
        else if (cmd_reg == CMD_DIV)
        begin
            unique case (k_reg)
                3'd0:    begin mul_a = acc_re_reg; mul_b = opr_reg; mdst = DST_RE; end
                3'd1:    begin mul_a = acc_im_reg; mul_b = opi_reg; mdst = DST_RE; end
                3'd2:    begin mul_a = acc_im_reg; mul_b = opr_reg; mdst = DST_IM; end
                3'd3:    begin mul_a = acc_re_reg; mul_b = opi_reg; mdst = DST_IM; msub = 1'b1; end
                3'd4:    begin mul_a = opr_reg; mul_b = opr_reg; mdst = DST_DEN; end
                3'd5:    begin mul_a = opi_reg; mul_b = opi_reg; mdst = DST_DEN; end
                default: mdst = DST_NONE;
            endcase
        end
        else if (cmd_reg == CMD_MAG)
        begin
            unique case (k_reg)
                3'd0:    begin mul_a = acc_re_reg; mul_b = acc_re_reg; mdst = DST_DEN; end
                3'd1:    begin mul_a = acc_im_reg; mul_b = acc_im_reg; mdst = DST_DEN; end
                default: mdst = DST_NONE;
            endcase
        end
    end

    // divider datapath: numerator selection, one restoring step, the saturated quotient word and the square root trial
    always_comb
    begin
        dsum   = dsel_reg ? sum_im_reg : sum_re_reg;
        dnum   = dsum[SUM_W-1] ? SUM_W'(-dsum) : SUM_W'(dsum);
        rem_sh = {rem_reg[PROD_W-2:0], nlow_reg[DATA_WIDTH-1]};
        q_bit  = (rem_sh >= den_reg);
        qword  = sm_to_word(dneg_reg, dovf_reg ? {{(SUM_W-DATA_WIDTH){1'b0}},
                            1'b1, {(DATA_WIDTH-1){1'b0}}}
                            : {{(SUM_W-DATA_WIDTH){1'b0}}, quo_reg});
        strial = sres_reg + sbit_reg;
    end

    // result of the request
    always_comb
    begin
        mul_sum = SUM_W'(sum_re_reg);
        mul_mag = '0;
        fin_re  = acc_re_reg;
        fin_im  = acc_im_reg;
        fin_mag = '0;
        fin_st  = ST_OK;
        unique case (cmd_reg)
            CMD_LOAD:
            begin
                fin_re = opr_reg;
                fin_im = opi_reg;
            end
            CMD_ADD:
            begin
                fin_re = sat_add(acc_re_reg, opr_reg);
                fin_im = sat_add(acc_im_reg, opi_reg);
            end
            CMD_SUB:
            begin
                // subtracting in a wider word keeps the most negative operand exact
                fin_re = sm_to_word(1'b0, '0);
                fin_im = fin_re;
                mul_sum = SUM_W'(acc_re_reg) - SUM_W'(opr_reg);
                fin_re = sm_to_word(mul_sum[SUM_W-1],
                         mul_sum[SUM_W-1] ? SUM_W'(-mul_sum) : SUM_W'(mul_sum));
                mul_sum = SUM_W'(acc_im_reg) - SUM_W'(opi_reg);
                fin_im = sm_to_word(mul_sum[SUM_W-1],
                         mul_sum[SUM_W-1] ? SUM_W'(-mul_sum) : SUM_W'(mul_sum));
            end
            CMD_MUL:
            begin
                // truncate toward zero: shift the magnitude, keep the sign
                mul_sum = sum_re_reg;
                mul_mag = (mul_sum[SUM_W-1] ? SUM_W'(-mul_sum) : SUM_W'(mul_sum)) >> FRAC_BITS;
                fin_re  = sm_to_word(mul_sum[SUM_W-1], mul_mag);
                mul_sum = sum_im_reg;
                mul_mag = (mul_sum[SUM_W-1] ? SUM_W'(-mul_sum) : SUM_W'(mul_sum)) >> FRAC_BITS;
                fin_im  = sm_to_word(mul_sum[SUM_W-1], mul_mag);
            end
            CMD_DIV:
            begin
                if (dz_reg)
                    fin_st = ST_DIV0;
                else
                begin
                    fin_re = qre_reg;
                    fin_im = qim_reg;
                end
            end
            CMD_MAG:
                fin_mag = sres_reg[31:0];
            CMD_BAD6, CMD_BAD7:
                fin_st = ST_ILLEGAL;
        endcase
    end

    assign finish = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if ((cmd_t'(cmd) == CMD_MUL) || (cmd_t'(cmd) == CMD_MAG) ||
                        ((cmd_t'(cmd) == CMD_DIV) &&
                         ((operand_real != '0) || (operand_imag != '0))))
                        state_next = S_MUL;
                    else
                        state_next = S_DONE;
                end
            end
            S_MUL:
            begin
                if (k_reg == nprod)
                begin
                    if (cmd_reg == CMD_DIV)
                        state_next = S_DIVSET;
                    else if (cmd_reg == CMD_MAG)
                        state_next = S_SQRT;
                    else
                        state_next = S_DONE;
                end
            end
            S_DIVSET:
                state_next = S_DIV;
            S_DIV:
            begin
                if (cnt_reg == CNT_W'(DATA_WIDTH - 1))
                    state_next = S_DIVEND;
            end
            S_DIVEND:
                state_next = dsel_reg ? S_DONE : S_DIVSET;
            S_SQRT:
            begin
                if (cnt_reg == CNT_W'(DATA_WIDTH - 1))
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (finish)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_re_reg    <= '0;
            acc_im_reg    <= '0;
            out_valid_reg <= 1'b0;
            pv_reg        <= 1'b0;
            k_reg         <= '0;
            cnt_reg       <= '0;
            dsel_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                acc_re_reg    <= fin_re;
                acc_im_reg    <= fin_im;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            pv_reg <= (state_reg == S_MUL) && (k_reg != nprod);
            if (state_reg == S_IDLE)
            begin
                k_reg    <= '0;
                dsel_reg <= 1'b0;
            end
            else if ((state_reg == S_MUL) && (k_reg != nprod))
                k_reg <= k_reg + 3'd1;
            if ((state_reg == S_DIVSET) || (state_reg == S_MUL))
                cnt_reg <= '0;
            else if ((state_reg == S_DIV) || (state_reg == S_SQRT))
                cnt_reg <= cnt_reg + CNT_W'(1);
            if (state_reg == S_DIVEND)
                dsel_reg <= 1'b1;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cmd_reg    <= cmd_t'(cmd);
            opr_reg    <= operand_real;
            opi_reg    <= operand_imag;
            dz_reg     <= (operand_real == '0) && (operand_imag == '0);
            sum_re_reg <= '0;
            sum_im_reg <= '0;
            den_reg    <= '0;
        end
        // shared multiplier, product summed in the following cycle
        prod_reg <= mul_a * mul_b;
        pdst_reg <= mdst;
        psub_reg <= msub;
        if (pv_reg)
        begin
            unique case (pdst_reg)
                DST_RE:   sum_re_reg <= psub_reg ? sum_re_reg - SUM_W'(prod_reg)
                                                 : sum_re_reg + SUM_W'(prod_reg);
                DST_IM:   sum_im_reg <= psub_reg ? sum_im_reg - SUM_W'(prod_reg)
                                                 : sum_im_reg + SUM_W'(prod_reg);
                DST_DEN:  den_reg    <= den_reg + prod_reg;
                DST_NONE: den_reg    <= den_reg;
            endcase
        end
        // divider setup: quotient at or above two to the word width saturates
        if (state_reg == S_DIVSET)
        begin
            dneg_reg <= dsum[SUM_W-1];
            dovf_reg <= (dnum >> FRAC_BITS) >= SUM_W'(den_reg);
            rem_reg  <= PROD_W'(dnum >> FRAC_BITS);
            nlow_reg <= {dnum[FRAC_BITS-1:0], {(DATA_WIDTH-FRAC_BITS){1'b0}}};
            quo_reg  <= '0;
        end
        if (state_reg == S_DIV)
        begin
            rem_reg  <= q_bit ? rem_sh - den_reg : rem_sh;
            nlow_reg <= {nlow_reg[DATA_WIDTH-2:0], 1'b0};
            quo_reg  <= {quo_reg[DATA_WIDTH-2:0], q_bit};
        end
        if (state_reg == S_DIVEND)
        begin
            if (dsel_reg)
                qim_reg <= qword;
            else
                qre_reg <= qword;
        end
        // square root, two radicand bits a step
        if ((state_reg == S_MUL) && (k_reg == nprod))
        begin
            sres_reg <= '0;
            sbit_reg <= {2'b01, {(PROD_W-2){1'b0}}};
        end
        if ((state_reg == S_MUL) && (k_reg == nprod) && !pv_reg)
            sx_reg <= den_reg;
        else if ((state_reg == S_MUL) && (k_reg == nprod))
            sx_reg <= den_reg + prod_reg;
        if (state_reg == S_SQRT)
        begin
            if (sx_reg >= strial)
            begin
                sx_reg   <= sx_reg - strial;
                sres_reg <= (sres_reg >> 1) + sbit_reg;
            end
            else
                sres_reg <= sres_reg >> 1;
            sbit_reg <= sbit_reg >> 2;
        end
        if (finish)
        begin
            res_re_reg <= fin_re;
            res_im_reg <= fin_im;
            mag_reg    <= fin_mag;
            st_reg     <= fin_st;
        end
    end

    // sequencer is always in exactly one state
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("sequencer state not one-hot");

    // divide by zero never reaches the divider
    a_dz_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVSET) |-> !dz_reg)
        else $error("divider started on a zero divisor");

    // no request is taken while one is in flight
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("request taken while busy");

    // a magnitude value appears only on a magnitude request
    a_mag: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && (cmd_reg != CMD_MAG)) |=> (magnitude_value == '0))
        else $error("magnitude value on another command");

    // divide by zero leaves the accumulator alone
    a_dz_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && (cmd_reg == CMD_DIV) && dz_reg) |=>
        (acc_re_reg == $past(acc_re_reg)) && (acc_im_reg == $past(acc_im_reg)))
        else $error("accumulator changed on divide by zero");

endmodule

>>> verif/tb.sv
// self-checking testbench for the complex accumulator alu
`timescale 1ns / 1ps

module tb;
    import cacc_pkg::*;

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;
    localparam int     CYCLE_LIMIT = 3000000;
    localparam int     DRAIN_CYCLES = 120;

    // one expected response of the block
    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic [31:0]        mag;
        logic [1:0]         st;
    } acc_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         cmd;
    logic signed [31:0] operand_real;
    logic signed [31:0] operand_imag;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] result_real;
    logic signed [31:0] result_imag;
    logic [31:0]        magnitude_value;
    logic [1:0]         status;

    // predictor state: the accumulator as the block should hold it
    logic signed [31:0] model_re;
    logic signed [31:0] model_im;

    acc_result_t expected_results[$];
    int          mismatches;
    int          cycle_count;
    int          out_stall;
    bit          out_taken;

    complex_accumulator_alu u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .operand_real   (operand_real),
        .operand_imag   (operand_imag),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_real    (result_real),
        .result_imag    (result_imag),
        .magnitude_value(magnitude_value),
        .status         (status)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // saturate a wide signed value to the word range
    function automatic logic signed [31:0] clamp_word(input logic signed [65:0] v);
        if (v > WORD_MAX)
            return 32'sh7fffffff;
        if (v < WORD_MIN)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // sign and magnitude to word, saturated
    function automatic logic signed [31:0] signed_from_mag(input logic neg,
                                                           input logic [95:0] mag);
        if (neg)
            return (mag >= 96'h8000_0000) ? 32'sh80000000 : -$signed({1'b0, mag[31:0]});
        return (mag >= 96'h8000_0000) ? 32'sh7fffffff : $signed(mag[31:0]);
    endfunction

    // floor of the square root, one root bit per pass
    function automatic logic [31:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= root + bitv)
            begin
                x = x - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root[31:0];
    endfunction

    // quotient of the q16.16 division, truncated toward zero, saturated
    function automatic logic signed [31:0] div_part(input logic signed [65:0] num,
                                                    input logic [65:0] den);
        logic [65:0] amag;
        logic [95:0] q;
        amag = num[65] ? -num : num;
        q = {14'd0, amag, 16'd0} / {30'd0, den};
        return signed_from_mag(num[65] && q != 0, q);
    endfunction

    // advance the accumulator by one request and return the expected response
    function automatic acc_result_t apply_request(input logic [2:0] op,
                                                  input logic signed [31:0] br,
                                                  input logic signed [31:0] bi);
        acc_result_t      r;
        logic signed [65:0] ar, ai, sr, si, pre, pim;
        logic [65:0]      den, mre, mim;
        ar = model_re;
        ai = model_im;
        sr = br;
        si = bi;
        r = '0;
        r.re = model_re;
        r.im = model_im;
        case (cmd_t'(op))
            CMD_LOAD:
            begin
                r.re = br;
                r.im = bi;
            end
            CMD_ADD:
            begin
                r.re = clamp_word(ar + sr);
                r.im = clamp_word(ai + si);
            end
            CMD_SUB:
            begin
                r.re = clamp_word(ar - sr);
                r.im = clamp_word(ai - si);
            end
            CMD_MUL:
            begin
                pre = ar * sr - ai * si;
                pim = ar * si + ai * sr;
                mre = pre[65] ? -pre : pre;
                mim = pim[65] ? -pim : pim;
                // truncation toward zero: shift the magnitude, keep the sign
                r.re = signed_from_mag(pre[65] && (mre >> FRAC_BITS) != 0,
                                       {30'd0, mre >> FRAC_BITS});
                r.im = signed_from_mag(pim[65] && (mim >> FRAC_BITS) != 0,
                                       {30'd0, mim >> FRAC_BITS});
            end
            CMD_DIV:
            begin
                den = sr * sr + si * si;
                if (den == 0)
                    r.st = ST_DIV0;
                else
                begin
                    r.re = div_part(ar * sr + ai * si, den);
                    r.im = div_part(ai * sr - ar * si, den);
                end
            end
            CMD_MAG:
            begin
                mre = ar * ar + ai * ai;
                r.mag = floor_sqrt(mre[63:0]);
            end
            default:
                r.st = ST_ILLEGAL;
        endcase
        model_re = r.re;
        model_im = r.im;
        return r;
    endfunction

    // predict on every accepted request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            model_re = '0;
            model_im = '0;
        end
        else if (in_valid && in_ready)
            expected_results.push_back(apply_request(cmd, operand_real, operand_imag));
    end

    // compare every accepted response with the oldest prediction
    always @(posedge clk)
    begin
        acc_result_t want;
        out_taken = rst_n && out_valid && out_ready;
        if (out_taken)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response re=%h im=%h", result_real, result_imag);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result_real !== want.re || result_imag !== want.im ||
                    magnitude_value !== want.mag || status !== want.st)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp re=%h im=%h mag=%h st=%0d got re=%h im=%h mag=%h st=%0d",
                                 want.re, want.im, want.mag, want.st,
                                 result_real, result_imag, magnitude_value, status);
                end
            end
        end
    end

    // response side back-pressure, a new wait drawn after each taken response
    always @(negedge clk)
    begin
        int draw;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall <= 0;
        end
        else if (out_taken)
        begin
            // at least a quarter of the responses are taken back to back
            draw = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            out_ready <= (draw == 0);
            out_stall <= (draw > 0) ? draw - 1 : 0;
        end
        else if (out_stall > 0)
        begin
            out_ready <= 1'b0;
            out_stall <= out_stall - 1;
        end
        else
            out_ready <= 1'b1;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** complex_accumulator_alu: FAILED **");
            $finish;
        end
    end

    // send one request, after a random gap, and hold it until taken
    task automatic send_request(input cmd_t op, input logic [31:0] br, input logic [31:0] bi);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        operand_real <= br;
        operand_imag <= bi;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // operand value: extremes, small q16.16 values or any word
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3, 4: return $urandom;
            default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        endcase
    endfunction

    task automatic test_load_and_saturation();
        send_request(CMD_LOAD, 32'h7fffffff, 32'h80000000);
        send_request(CMD_ADD, 32'h00000001, 32'hffffffff);
        send_request(CMD_SUB, 32'hffffffff, 32'h00000001);
        send_request(CMD_MAG, 32'h12345678, 32'h9abcdef0);
        send_request(CMD_LOAD, 32'h80000000, 32'h80000000);
        send_request(CMD_MAG, 32'h0, 32'h0);
        send_request(CMD_SUB, 32'h80000000, 32'h7fffffff);
        send_request(CMD_ADD, 32'hffffffff, 32'hffffffff);
    endtask

    task automatic test_multiply();
        send_request(CMD_LOAD, 32'h00018000, 32'hffff0000);
        send_request(CMD_MUL, 32'h00020000, 32'h00008000);
        send_request(CMD_MUL, 32'h7fffffff, 32'h80000000);
        send_request(CMD_LOAD, 32'hffffffff, 32'h00000001);
        send_request(CMD_MUL, 32'h00000001, 32'h00000001);
    endtask

    task automatic test_divide();
        send_request(CMD_LOAD, 32'h00030000, 32'h00010000);
        send_request(CMD_DIV, 32'h0, 32'h0);
        send_request(CMD_DIV, 32'h00010000, 32'hffff0000);
        send_request(CMD_DIV, 32'h00000001, 32'h0);
        send_request(CMD_DIV, 32'h80000000, 32'h80000000);
        send_request(CMD_LOAD, 32'hfffd0000, 32'h00000007);
        send_request(CMD_DIV, 32'h00000000, 32'hfffe0000);
    endtask

    task automatic test_illegal();
        send_request(CMD_BAD6, 32'hffffffff, 32'hffffffff);
        send_request(CMD_BAD7, 32'h0, 32'h0);
        send_request(CMD_MAG, 32'hffffffff, 32'h0);
    endtask

    task automatic test_random(input int count);
        cmd_t op;
        for (int i = 0; i < count; i++)
        begin
            // reload now and then so the accumulator does not sit on a rail
            if ($urandom_range(0, 7) == 0)
                op = CMD_LOAD;
            else
                op = cmd_t'($urandom_range(0, 7));
            send_request(op, pick_operand(), pick_operand());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_LOAD;
        operand_real = '0;
        operand_imag = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_load_and_saturation();
        test_multiply();
        test_divide();
        test_illegal();
        test_random(1130);
        in_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("** complex_accumulator_alu: PASSED **");
        else
            $display("** complex_accumulator_alu: FAILED **");
        $finish;
    end

endmodule
